FILE: hdl/cqtm_pkg.sv
// ----------------------------------------------------------------------------
// cqtm_pkg
// Types, codes and helper constants shared by the clock quality monitor.
// ----------------------------------------------------------------------------
package cqtm_pkg;

  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned NUM_COUNTERS = 8;
  localparam logic [30:0] COUNT_MAX    = '1;

  localparam logic CMD_TAG     = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] REG_TRACKED_STREAM = 2'd0;
  localparam logic [1:0] REG_REPORT_ALL     = 2'd1;
  localparam logic [1:0] REG_BAD_CODE       = 2'd2;

  typedef enum logic [2:0] {
    CAT_LOCKED   = 3'd0,
    CAT_UNLOCKED = 3'd1,
    CAT_UNKNOWN  = 3'd2,
    CAT_ERROR    = 3'd3,
    CAT_NONE     = 3'd4
  } cat_t;

  typedef enum logic [3:0] {
    IDX_TOTAL    = 4'd0,
    IDX_LOCKED   = 4'd1,
    IDX_UNLOCKED = 4'd2,
    IDX_UNKNOWN  = 4'd3,
    IDX_ERROR    = 4'd4,
    IDX_LOST     = 4'd5,
    IDX_GAINED   = 4'd6,
    IDX_ANOMALY  = 4'd7,
    IDX_QUALITY  = 4'd8,
    IDX_RECORD   = 4'd9
  } cnt_idx_t;

  typedef struct packed {
    logic              command;
    logic              is_end_tag;
    logic signed [7:0] quality;
    logic [7:0]        stream_id;
    logic [31:0]       ext_time;
    logic [31:0]       record_number;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic               bad_code_seen;
    logic [2:0]         category;
    logic               quality_changed;
    logic               illegal_transition;
    logic               time_went_back;
    logic [3:0]         counter_index;
    logic signed [31:0] counter_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } cfg_word_t;

  // one bit per counter bumped by a tag, apart from the anomaly counter
  typedef struct packed {
    logic total;
    logic locked;
    logic unlocked;
    logic unknown;
    logic error;
    logic lost;
    logic gained;
  } inc_t;

  // front-to-back queue entry
  typedef struct packed {
    logic              is_report;
    logic              bad;
    cat_t              cat;
    logic              changed;
    logic              illegal;
    logic              back;
    inc_t              inc;
    logic [1:0]        anom_inc;
    logic signed [7:0] snap_quality;
    logic [31:0]       snap_record;
  } qent_t;

endpackage

FILE: hdl/cqtm_if.sv
// ----------------------------------------------------------------------------
// cqtm_if
// Valid/ready channels for tag input, result output and register writes.
// ----------------------------------------------------------------------------
interface cqtm_in_if ();
  logic               valid;
  logic               ready;
  cqtm_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cqtm_out_if ();
  logic                valid;
  logic                ready;
  cqtm_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cqtm_cfg_if ();
  logic                valid;
  logic                ready;
  cqtm_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/cqtm_front.sv
// ----------------------------------------------------------------------------
// cqtm_front
// Accepts tags and report commands, classifies them against the tracking
// state and the registers, and queues one entry per result-producing word.
// ----------------------------------------------------------------------------
module cqtm_front (
  input  logic                clk,
  input  logic                rst_n,
  cqtm_in_if.sink             in_ch,
  cqtm_cfg_if.sink            cfg_ch,
  output logic                q_push,
  output cqtm_pkg::qent_t     q_data,
  input  logic                q_full
);
  import cqtm_pkg::*;

  logic [7:0]        tracked_r;
  logic              report_all_r;
  logic signed [7:0] bad_code_r;

  logic              await_r, await_nxt;
  logic              skip_r, skip_nxt;
  logic signed [7:0] prev_q_r, prev_q_nxt;
  logic [31:0]       prev_ext_r, prev_ext_nxt;
  logic [31:0]       prev_rec_r, prev_rec_nxt;

  logic              acc;
  logic              tag_valid;
  logic signed [7:0] q;
  logic [8:0]        prev_p1;
  qent_t             ent;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign acc          = in_ch.valid && in_ch.ready;
  assign q            = in_ch.data.quality;
  assign prev_p1      = {prev_q_r[7], prev_q_r} + 9'd1;

  always_comb begin
    ent          = '0;
    ent.cat      = CAT_NONE;
    q_push       = 1'b0;
    tag_valid    = 1'b1;
    await_nxt    = await_r;
    skip_nxt     = skip_r;
    prev_q_nxt   = prev_q_r;
    prev_ext_nxt = prev_ext_r;
    prev_rec_nxt = prev_rec_r;
    if (acc) begin
      if (in_ch.data.command == CMD_REPORT) begin
        if (!await_r) begin
          q_push           = 1'b1;
          ent.is_report    = 1'b1;
          ent.snap_quality = prev_q_r;
          ent.snap_record  = prev_rec_r;
          await_nxt        = 1'b1;
        end
      end else begin
        q_push = 1'b1;
        if (in_ch.data.is_end_tag && skip_r) begin
          skip_nxt = 1'b0;
        end else begin
          if (!in_ch.data.is_end_tag) skip_nxt = 1'b0;
          if (q == bad_code_r) ent.bad = 1'b1;
          if (in_ch.data.stream_id != tracked_r) begin
            if (!in_ch.data.is_end_tag) skip_nxt = 1'b1;
          end else begin
            ent.inc.total = 1'b1;
            priority if (q == 8'sd1) begin
              ent.cat        = CAT_LOCKED;
              ent.inc.locked = 1'b1;
            end else if (q > 8'sd1 && q <= 8'sd6) begin
              ent.cat          = CAT_UNLOCKED;
              ent.inc.unlocked = 1'b1;
            end else if (q > 8'sd6) begin
              ent.cat         = CAT_UNKNOWN;
              ent.inc.unknown = 1'b1;
              tag_valid       = 1'b0;
            end else if (q < 8'sd0) begin
              ent.cat       = CAT_ERROR;
              ent.inc.error = 1'b1;
              tag_valid     = 1'b0;
            end else begin
              // code zero: valid unlocked, counted in the total only
              ent.cat = CAT_UNLOCKED;
            end
            if (!tag_valid) begin
              if (!in_ch.data.is_end_tag) skip_nxt = 1'b1;
            end else begin
              if (await_r) begin
                await_nxt = 1'b0;
              end else if (prev_q_r != q) begin
                ent.changed    = 1'b1;
                ent.inc.lost   = (prev_q_r == 8'sd1);
                ent.inc.gained = (q == 8'sd1);
                if (report_all_r) begin
                  ent.illegal = (q != 8'sd1) && ({q[7], q} != prev_p1);
                  ent.back    = (in_ch.data.ext_time < prev_ext_r);
                end
              end
              prev_q_nxt   = q;
              prev_ext_nxt = in_ch.data.ext_time;
              prev_rec_nxt = in_ch.data.record_number;
            end
          end
        end
      end
    end
    ent.anom_inc = {1'b0, ent.bad} + {1'b0, ent.illegal};
    q_data       = ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r    <= '0;
      report_all_r <= 1'b0;
      bad_code_r   <= -8'sd1;
      await_r      <= 1'b1;
      skip_r       <= 1'b0;
      prev_q_r     <= '0;
      prev_ext_r   <= '0;
      prev_rec_r   <= '0;
    end else begin
      await_r    <= await_nxt;
      skip_r     <= skip_nxt;
      prev_q_r   <= prev_q_nxt;
      prev_ext_r <= prev_ext_nxt;
      prev_rec_r <= prev_rec_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.data.index)
          REG_TRACKED_STREAM: tracked_r    <= cfg_ch.data.value;
          REG_REPORT_ALL:     report_all_r <= cfg_ch.data.value[0];
          REG_BAD_CODE:       bad_code_r   <= cfg_ch.data.value;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/cqtm_fifo.sv
// ----------------------------------------------------------------------------
// cqtm_fifo
// Short register queue between the classifier and the counter back end.
// ----------------------------------------------------------------------------
module cqtm_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      if (push && !pop)      count_r <= CW'(count_r + 1'b1);
      else if (pop && !push) count_r <= CW'(count_r - 1'b1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: hdl/cqtm_back.sv
// ----------------------------------------------------------------------------
// cqtm_back
// Applies queued counter updates, emits tag status words and sequences the
// ten words of a report through the output register.
// ----------------------------------------------------------------------------
module cqtm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  cqtm_pkg::qent_t q_data,
  output logic            q_pop,
  cqtm_out_if.source      out_ch
);
  import cqtm_pkg::*;

  logic [30:0]       cnt_r [NUM_COUNTERS];
  logic [30:0]       cnt_nxt [NUM_COUNTERS];
  logic [1:0]        amt [NUM_COUNTERS];
  logic              busy_r, busy_nxt;
  cnt_idx_t          idx_r, idx_nxt;
  logic signed [7:0] snap_q_r;
  logic [31:0]       snap_rec_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;
  logic              slot_free;
  logic [31:0]       rpt_value;

  function automatic logic [30:0] sat_add(input logic [30:0] c, input logic [1:0] a);
    logic [31:0] s;
    s = {1'b0, c} + {30'b0, a};
    return s[31] ? COUNT_MAX : s[30:0];
  endfunction

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign q_pop        = !busy_r && !q_empty && slot_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    amt[IDX_TOTAL[2:0]]    = {1'b0, q_data.inc.total};
    amt[IDX_LOCKED[2:0]]   = {1'b0, q_data.inc.locked};
    amt[IDX_UNLOCKED[2:0]] = {1'b0, q_data.inc.unlocked};
    amt[IDX_UNKNOWN[2:0]]  = {1'b0, q_data.inc.unknown};
    amt[IDX_ERROR[2:0]]    = {1'b0, q_data.inc.error};
    amt[IDX_LOST[2:0]]     = {1'b0, q_data.inc.lost};
    amt[IDX_GAINED[2:0]]   = {1'b0, q_data.inc.gained};
    amt[IDX_ANOMALY[2:0]]  = q_data.anom_inc;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_nxt[i] = (q_pop && !q_data.is_report) ? sat_add(cnt_r[i], amt[i]) : cnt_r[i];
    end
  end

  always_comb begin
    unique case (idx_r)
      IDX_QUALITY: rpt_value = {{24{snap_q_r[7]}}, snap_q_r};
      IDX_RECORD:  rpt_value = snap_rec_r;
      default:     rpt_value = {1'b0, cnt_r[idx_r[2:0]]};
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (busy_r) begin
      if (slot_free) begin
        out_valid_nxt                = 1'b1;
        out_data_nxt                 = '0;
        out_data_nxt.kind            = KIND_REPORT;
        out_data_nxt.counter_index   = idx_r;
        out_data_nxt.counter_value   = rpt_value;
        out_data_nxt.last            = (idx_r == IDX_RECORD);
        if (idx_r == IDX_RECORD) busy_nxt = 1'b0;
        else idx_nxt = cnt_idx_t'(4'(idx_r + 4'd1));
      end
    end else if (q_pop) begin
      if (q_data.is_report) begin
        busy_nxt = 1'b1;
        idx_nxt  = IDX_TOTAL;
      end else begin
        out_valid_nxt                   = 1'b1;
        out_data_nxt                    = '0;
        out_data_nxt.kind               = KIND_STATUS;
        out_data_nxt.bad_code_seen      = q_data.bad;
        out_data_nxt.category           = q_data.cat;
        out_data_nxt.quality_changed    = q_data.changed;
        out_data_nxt.illegal_transition = q_data.illegal;
        out_data_nxt.time_went_back     = q_data.back;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.is_report) begin
      snap_q_r   <= q_data.snap_quality;
      snap_rec_r <= q_data.snap_record;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_r[i] <= '0;
      busy_r      <= 1'b0;
      idx_r       <= IDX_TOTAL;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_r[i] <= cnt_nxt[i];
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= IDX_RECORD)
    else $error("report index out of range");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("queue popped during report");
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |->
      out_data_r.kind == KIND_REPORT && out_data_r.counter_index == IDX_RECORD)
    else $error("last flag on wrong word");

endmodule

FILE: hdl/clock_quality_transition_monitor.sv
// A tag's status word passes through the queue and then the output register.
// One tag per cycle is accepted while the queue is not full; a report holds the
// counter back end for one dequeue followed by its ten report words.
// The input keeps accepting into a FIFO_DEPTH-entry queue while the back end works.
// Reset (rst_n low, synchronous): counters cleared, registers to defaults,
// waiting for the first valid tag, queue and output register emptied.
// ----------------------------------------------------------------------------
// clock_quality_transition_monitor
// Classifies clock quality codes of record time tags and keeps sync counters.
// ----------------------------------------------------------------------------
module clock_quality_transition_monitor #(
  parameter int unsigned FIFO_DEPTH = cqtm_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  cqtm_in_if.sink     in_ch,
  cqtm_out_if.source  out_ch,
  cqtm_cfg_if.sink    cfg_ch
);
  import cqtm_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  qent_t q_wdata, q_rdata;

  cqtm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  cqtm_fifo #(
    .T     (qent_t),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  cqtm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: sim/cqtm_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqtm_word_checker
// Watches the tag, result and register channels of the clock quality monitor.
// Keeps its own register copies, counters and transition state, works out the
// words each accepted tag or report command must give, and compares every
// result word field by field, in order.
// ----------------------------------------------------------------------------
module cqtm_word_checker (
  input  logic clk,
  input  logic rst_n,
  cqtm_in_if   in_ch,
  cqtm_out_if  out_ch,
  cqtm_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   in_words,
  output int   status_words,
  output int   report_words
);
  import cqtm_pkg::*;

  localparam logic [31:0] SAT_LIMIT   = 32'h7fff_ffff;

  // register copies
  logic [7:0]        trk_stream;
  logic              all_transitions;
  logic signed [7:0] bad_code;

  // counters indexed by cnt_idx_t, total through anomalies
  logic [31:0]       tally [NUM_COUNTERS];
  logic              awaiting_valid;
  logic signed [7:0] last_q;
  logic [31:0]       last_ext;
  logic [31:0]       last_rec;
  logic              skip_end;

  out_word_t         awaited_words [$];

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    fail_count++;
    $display("[%0t] result word %0d: %s expected %0h, got %0h", $time,
             status_words + report_words, what, want_v, got_v);
  endtask

  function automatic void bump(input cnt_idx_t idx);
    if (tally[idx] < SAT_LIMIT) tally[idx] = tally[idx] + 32'd1;
  endfunction

  function automatic void account_input(input in_word_t w);
    out_word_t         r;
    logic signed [7:0] q;
    logic              usable;
    int                k;
    r = '0;
    q = w.quality;
    if (w.command == CMD_REPORT) begin
      // silent until a valid tag has come since reset or the last report
      if (awaiting_valid) return;
      for (k = 0; k < 10; k++) begin
        r = '0;
        r.kind = KIND_REPORT;
        r.counter_index = 4'(k);
        if (k < 8) r.counter_value = tally[k];
        else if (k == 8) r.counter_value = {{24{last_q[7]}}, last_q};
        else r.counter_value = last_rec;
        r.last = (k == 9);
        awaited_words.push_back(r);
      end
      awaiting_valid = 1'b1;
      return;
    end

    r.kind = KIND_STATUS;
    r.category = CAT_NONE;
    if (w.is_end_tag && skip_end) begin
      // end tag of a rejected record: not even the bad code is looked at
      skip_end = 1'b0;
    end else begin
      if (!w.is_end_tag) skip_end = 1'b0;
      if (q == bad_code) begin
        r.bad_code_seen = 1'b1;
        bump(IDX_ANOMALY);
      end
      if (w.stream_id != trk_stream) begin
        if (!w.is_end_tag) skip_end = 1'b1;
      end else begin
        usable = 1'b1;
        bump(IDX_TOTAL);
        if (q == 8'sd1) begin
          r.category = CAT_LOCKED;
          bump(IDX_LOCKED);
        end else if (q > 8'sd1 && q <= 8'sd6) begin
          r.category = CAT_UNLOCKED;
          bump(IDX_UNLOCKED);
        end else if (q > 8'sd6) begin
          r.category = CAT_UNKNOWN;
          bump(IDX_UNKNOWN);
          usable = 1'b0;
        end else if (q < 8'sd0) begin
          r.category = CAT_ERROR;
          bump(IDX_ERROR);
          usable = 1'b0;
        end else begin
          // code zero: total only, then handled as unlocked
          r.category = CAT_UNLOCKED;
        end

        if (!usable) begin
          if (!w.is_end_tag) skip_end = 1'b1;
        end else begin
          if (awaiting_valid) begin
            awaiting_valid = 1'b0;
          end else if (last_q != q) begin
            r.quality_changed = 1'b1;
            if (last_q == 8'sd1) bump(IDX_LOST);
            if (q == 8'sd1) bump(IDX_GAINED);
            if (all_transitions) begin
              if (q != 8'sd1 && int'(q) != int'(last_q) + 1) begin
                r.illegal_transition = 1'b1;
                bump(IDX_ANOMALY);
              end
              if (w.ext_time < last_ext) r.time_went_back = 1'b1;
            end
          end
          last_q   = q;
          last_ext = w.ext_time;
          last_rec = w.record_number;
        end
      end
    end
    awaited_words.push_back(r);
  endfunction

  task automatic take_word(input out_word_t got);
    out_word_t want;
    if (got.kind == KIND_REPORT) report_words++;
    else status_words++;
    if (awaited_words.size() == 0) begin
      report_mismatch("unexpected word, counter index", '0, 32'(got.counter_index));
      return;
    end
    want = awaited_words.pop_front();
    if (got.kind !== want.kind)
      report_mismatch("kind", 32'(want.kind), 32'(got.kind));
    if (got.bad_code_seen !== want.bad_code_seen)
      report_mismatch("bad_code_seen", 32'(want.bad_code_seen), 32'(got.bad_code_seen));
    if (got.category !== want.category)
      report_mismatch("category", 32'(want.category), 32'(got.category));
    if (got.quality_changed !== want.quality_changed)
      report_mismatch("quality_changed", 32'(want.quality_changed),
                      32'(got.quality_changed));
    if (got.illegal_transition !== want.illegal_transition)
      report_mismatch("illegal_transition", 32'(want.illegal_transition),
                      32'(got.illegal_transition));
    if (got.time_went_back !== want.time_went_back)
      report_mismatch("time_went_back", 32'(want.time_went_back),
                      32'(got.time_went_back));
    if (got.counter_index !== want.counter_index)
      report_mismatch("counter_index", 32'(want.counter_index), 32'(got.counter_index));
    if (got.counter_value !== want.counter_value)
      report_mismatch("counter_value", want.counter_value, got.counter_value);
    if (got.last !== want.last)
      report_mismatch("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trk_stream      = '0;
      all_transitions = 1'b0;
      bad_code        = -8'sd1;
      foreach (tally[i]) tally[i] = '0;
      awaiting_valid  = 1'b1;
      last_q          = '0;
      last_ext        = '0;
      last_rec        = '0;
      skip_end        = 1'b0;
      awaited_words.delete();
      fail_count      = 0;
      in_words        = 0;
      status_words    = 0;
      report_words    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_TRACKED_STREAM: trk_stream = cfg_ch.data.value;
          REG_REPORT_ALL:     all_transitions = cfg_ch.data.value[0];
          REG_BAD_CODE:       bad_code = cfg_ch.data.value;
          default: ;  // spare index, write has no effect
        endcase
      end
      // a word leaving now belongs to an earlier input
      if (out_ch.valid && out_ch.ready) take_word(out_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        in_words++;
        account_input(in_ch.data);
      end
    end
    pending <= awaited_words.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the clock quality monitor: a directed pass over the code
// classes, skipped end tags and transition rules, then random record streams
// under several register settings with random stalls on both channels and one
// long output hold-off. Checking is done by cqtm_word_checker.
// ----------------------------------------------------------------------------
module tb;
  import cqtm_pkg::*;

  localparam int         HALF_PERIOD  = 10;
  localparam int         RESET_CYCLES = 12;
  localparam int         PHASE_ITEMS  = 48;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         IDLE_LIMIT   = 2000;
  localparam logic [1:0] REG_SPARE    = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cqtm_in_if  in_ch ();
  cqtm_out_if out_ch ();
  cqtm_cfg_if cfg_ch ();

  int fail_count, pending, in_words, status_words, report_words;
  int settings_used = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  // what the stimulus knows of the current setting, to shape records
  int          cur_stream = 0;
  int          cur_bad    = -1;
  int          cur_q      = 1;
  logic [31:0] ext_clock;
  logic [31:0] rec_no;

  clock_quality_transition_monitor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cqtm_word_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .in_words     (in_words),
    .status_words (status_words),
    .report_words (report_words)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(99));
    if (r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic in_word_t tag(input logic is_end, input int q, input int stream,
                                   input logic [31:0] ext, input logic [31:0] rec);
    in_word_t w;
    w.command       = CMD_TAG;
    w.is_end_tag    = is_end;
    w.quality       = 8'(q);
    w.stream_id     = 8'(stream);
    w.ext_time      = ext;
    w.record_number = rec;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w = tag(1'($urandom), int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
            $urandom, $urandom);
    w.command = ($urandom_range(9) == 0) ? CMD_REPORT : CMD_TAG;
    return w;
  endfunction

  function automatic in_word_t report_word();
    in_word_t w;
    w = random_word();
    w.command = CMD_REPORT;
    return w;
  endfunction

  // mostly locked and legal steps, some jumps, unknown, error and bad codes
  function automatic int pick_quality();
    int r;
    r = int'($urandom_range(99));
    if (r < 35) return 1;
    if (r < 55) return (cur_q >= 1 && cur_q < 6) ? cur_q + 1 : 2;
    if (r < 78) return int'($urandom_range(0, 6));
    if (r < 86) return int'($urandom_range(7, 127));
    if (r < 95) return -int'($urandom_range(1, 128));
    return cur_bad;
  endfunction

  task automatic send_word(input in_word_t w);
    int g;
    g = idle_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every expected word is out and the back end has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_word_t c;
    c.index = idx;
    c.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int stream, input bit all, input int bad);
    write_reg(REG_TRACKED_STREAM, 8'(stream));
    write_reg(REG_REPORT_ALL, {7'd0, all});
    write_reg(REG_BAD_CODE, 8'(bad));
    cur_stream = stream;
    cur_bad    = bad;
    settings_used++;
  endtask

  task automatic run_random(input int n, input bit with_hold_off);
    int sent;
    int qb, qe, s;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < n) begin
      if (with_hold_off && !held && sent >= 8) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_word(random_word());
        sent++;
      end else begin
        qb = pick_quality();
        qe = ($urandom_range(99) < 70) ? qb : pick_quality();
        s  = ($urandom_range(99) < 88) ? cur_stream : int'($urandom_range(0, 255));
        if ($urandom_range(99) < 8) ext_clock -= 32'($urandom_range(1, 5000));
        else ext_clock += 32'($urandom_range(1, 1000));
        rec_no++;
        send_word(tag(1'b0, qb, s, ext_clock, rec_no));
        sent++;
        // now and then a record loses its end tag
        if ($urandom_range(99) < 90) begin
          send_word(tag(1'b1, qe, s, ext_clock + 32'($urandom_range(0, 50)), rec_no));
          sent++;
        end
        if (s == cur_stream && qb >= 0 && qb <= 6) cur_q = qb;
        if ($urandom_range(99) < 8) begin
          send_word(report_word());
          sent++;
        end
      end
    end
    send_word(report_word());
  endtask

  // result side: random stalls, one long hold-off on request
  always begin : result_sink
    int g;
    @(posedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end else begin
      g = idle_gap();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    out_ch.ready <= 1'b1;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d words still expected",
                 quiet, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    ext_clock    = $urandom;
    rec_no       = $urandom;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass on reset register values
    send_word(report_word());                          // nothing valid yet: silent
    send_word(tag(1'b0, 1, 0, 32'd100, 32'd1));        // first valid tag
    send_word(tag(1'b1, 1, 0, 32'd110, 32'd1));
    send_word(tag(1'b0, 2, 0, 32'd120, 32'd2));        // sync lost
    send_word(tag(1'b1, 0, 0, 32'd130, 32'd2));        // code zero
    send_word(tag(1'b0, 6, 0, 32'd140, 32'd3));
    send_word(tag(1'b1, 6, 0, 32'd150, 32'd3));
    send_word(tag(1'b0, 7, 0, 32'd160, 32'd4));        // unknown: end tag skipped
    send_word(tag(1'b1, -1, 0, 32'd170, 32'd4));
    send_word(tag(1'b0, -1, 0, 32'd180, 32'd5));       // error plus bad code
    send_word(tag(1'b1, 1, 0, 32'd190, 32'd5));
    send_word(tag(1'b0, -1, 5, 32'd200, 32'd6));       // foreign stream
    send_word(tag(1'b1, -1, 5, 32'd210, 32'd6));
    send_word(tag(1'b0, 1, 0, 32'd220, 32'd7));        // sync gained
    send_word(tag(1'b1, -1, 255, 32'd230, 32'd7));     // foreign end tag, still checked
    send_word(tag(1'b0, 127, 0, 32'hffff_ffff, 32'hffff_ffff));
    send_word(tag(1'b1, -128, 0, 32'd0, 32'd0));
    send_word(tag(1'b0, -128, 0, 32'd0, 32'd0));
    send_word(report_word());
    send_word(report_word());                          // rearmed: silent
    settle();

    // transition rules with full reporting
    configure(0, 1'b1, 127);
    send_word(tag(1'b0, 1, 0, 32'd1000, 32'd20));
    send_word(tag(1'b0, 3, 0, 32'd500, 32'd21));       // skipped step, time back
    send_word(tag(1'b0, 4, 0, 32'd600, 32'd22));       // legal step
    send_word(tag(1'b0, 1, 0, 32'd100, 32'd23));       // relock, time back
    send_word(tag(1'b0, 0, 0, 32'd200, 32'd24));
    send_word(tag(1'b1, 127, 0, 32'd300, 32'd24));
    send_word(report_word());
    settle();

    configure(0, 1'b1, -1);
    run_random(PHASE_ITEMS, 1'b0);
    settle();

    // no idling on either side
    calm = 1'b1;
    configure(255, 1'b0, -128);
    run_random(PHASE_ITEMS, 1'b0);
    settle();
    calm = 1'b0;

    configure(int'($urandom_range(1, 254)), 1'b1, 0);
    run_random(PHASE_ITEMS, 1'b1);
    settle();

    write_reg(REG_SPARE, 8'($urandom));
    configure(int'($urandom_range(1, 254)), 1'b1, int'($urandom_range(2, 6)));
    run_random(PHASE_ITEMS, 1'b0);
    settle();

    $display("covered %0d input words, %0d status and %0d counter words, %0d settings",
             in_words, status_words, report_words, settings_used);
    $display("with random stalls, a %0d-cycle result hold-off and extreme stream/code values",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cqtm_pkg.sv
hdl/cqtm_if.sv
hdl/cqtm_front.sv
hdl/cqtm_fifo.sv
hdl/cqtm_back.sv
hdl/clock_quality_transition_monitor.sv
sim/cqtm_word_checker.sv
sim/tb.sv
